FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is asserted.
`define TPAG_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that is also checked during reset.
`define TPAG_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/tpag_pkg.sv
// Package for the tensor permute address generator: sizes, register indexes,
// the controller/datapath command and status types and the rank clamp.
package tpag_pkg;

    localparam int MAX_RANK   = 8;
    localparam int SIZE_BITS  = 16;
    localparam int ADDR_BITS  = 32;
    localparam int DATA_BITS  = 64;

    // Fixed by the register layout.
    localparam int NUM_AXES   = 8;
    localparam int AXIS_W     = $clog2(NUM_AXES);
    localparam int FIELD_W    = 16;
    localparam int ORDER_W    = 3;
    localparam int RANK_W     = 4;
    localparam int ORDER_BITS = 24;
    localparam int CFG_W      = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int OUT_ADDR_W = 32;
    localparam int ELEM_W     = 64;

    localparam logic [CFG_IDX_W-1:0] REG_RANK       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_ORDER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZES_LOW  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIZES_HIGH = 2'd3;

    localparam logic [RANK_W-1:0]     RANK_RESET  = 4'd1;
    localparam logic [ORDER_BITS-1:0] ORDER_RESET = 24'hFAC688;

    typedef logic [AXIS_W-1:0] t_axis;

    typedef struct packed {
        logic  start;        // latch sizes, clear counters, seed stride table
        logic  stride_step;  // one destination axis of the stride product chain
        logic  rw_mul;       // rewind product of one axis
        logic  rw_acc;       // step entry of one axis, accumulate rewind
        logic  fire;         // advance the odometer and load the output register
        logic  use_hold;     // take the element from the hold register
        t_axis idx;
        t_axis last_axis;    // rank minus one
    } t_dp_cmd;

    typedef struct packed {
        logic wrap;          // every axis in use sits at its limit
        logic out_free;      // output register can take a result this cycle
    } t_dp_status;

    function automatic t_axis clamp_last(input logic [RANK_W-1:0] rank);
        t_axis last;
        if (rank == '0) begin
            last = '0;
        end else if (int'(rank) > MAX_RANK) begin
            last = AXIS_W'(MAX_RANK - 1);
        end else begin
            last = AXIS_W'(rank - 1'b1);
        end
        return last;
    endfunction

endpackage

FILE: rtl/tensor_permute_address_gen_unit.sv
// The first element of a tensor is taken at once; its result appears after the stride chain
// and rewind pass, once the output register is free. The remaining elements run one per
// cycle while the receiver does not stall, each result in the cycle after its transfer.
// Reset (synchronous, active low) returns the controller to idle, empties the output
// register and restores the configuration registers; tables are rebuilt at every tensor start.
module tensor_permute_address_gen_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [tpag_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tpag_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [tpag_pkg::ELEM_W-1:0]       i_element_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [tpag_pkg::OUT_ADDR_W-1:0]   o_dest_address,
    output logic [tpag_pkg::ELEM_W-1:0]       o_element_out,
    output logic                              o_last_element
);
    import tpag_pkg::*;

    // The configuration registers live here. Rank and the axis sizes are copied
    // into the controller and datapath when a tensor starts, so a write while a
    // tensor is running only takes effect at the next tensor. The axis order is
    // read during the set-up pass, which follows straight on from the first
    // transfer of a tensor.
    logic [RANK_W-1:0]     r_rank;
    logic [ORDER_BITS-1:0] r_axis_order;
    logic [CFG_W-1:0]      r_sizes_low;
    logic [CFG_W-1:0]      r_sizes_high;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank       <= RANK_RESET;
            r_axis_order <= ORDER_RESET;
            r_sizes_low  <= '0;
            r_sizes_high <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_RANK:       r_rank       <= i_cfg_data[RANK_W-1:0];
                REG_AXIS_ORDER: r_axis_order <= i_cfg_data[ORDER_BITS-1:0];
                REG_SIZES_LOW:  r_sizes_low  <= i_cfg_data;
                REG_SIZES_HIGH: r_sizes_high <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // The controller sequences the set-up pass and then releases the input
    // channel; the datapath holds the tables, the axis counters and the
    // output register, which decouples the two channels.
    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    tpag_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_rank     (r_rank),
        .i_status   (w_status),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    tpag_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_axis_order   (r_axis_order),
        .i_sizes_low    (r_sizes_low),
        .i_sizes_high   (r_sizes_high),
        .i_element_data (i_element_data),
        .i_out_stall    (i_out_stall),
        .o_status       (w_status),
        .o_out_valid    (o_out_valid),
        .o_dest_address (o_dest_address),
        .o_element_out  (o_element_out),
        .o_last_element (o_last_element)
    );

endmodule

FILE: rtl/tpag_ctrl.sv
// Controller state machine of the tensor permute address generator.
// Depends on tpag_pkg for the command and status types.
module tpag_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic [tpag_pkg::RANK_W-1:0]   i_rank,
    input  tpag_pkg::t_dp_status          i_status,
    output logic                          o_in_stall,
    output tpag_pkg::t_dp_cmd             o_cmd
);
    import tpag_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_STRIDE = 3'd1;
    localparam logic [2:0] ST_RW_MUL = 3'd2;
    localparam logic [2:0] ST_RW_ACC = 3'd3;
    localparam logic [2:0] ST_FIRST  = 3'd4;
    localparam logic [2:0] ST_RUN    = 3'd5;

    logic [2:0] r_state, n_state;
    t_axis      r_idx, n_idx;
    t_axis      r_last, n_last;

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_last     = r_last;
        o_in_stall = 1'b1;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                n_last     = clamp_last(i_rank);
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_idx       = n_last;
                    n_state     = ST_STRIDE;
                end
            end
            ST_STRIDE: begin
                o_cmd.stride_step = 1'b1;
                if (r_idx == '0) begin
                    n_idx   = r_last;
                    n_state = ST_RW_MUL;
                end else begin
                    n_idx = r_idx - 1'b1;
                end
            end
            ST_RW_MUL: begin
                o_cmd.rw_mul = 1'b1;
                n_state      = ST_RW_ACC;
            end
            ST_RW_ACC: begin
                o_cmd.rw_acc = 1'b1;
                if (r_idx == '0) begin
                    n_state = ST_FIRST;
                end else begin
                    n_idx   = r_idx - 1'b1;
                    n_state = ST_RW_MUL;
                end
            end
            ST_FIRST: begin
                if (i_status.out_free) begin
                    o_cmd.fire     = 1'b1;
                    o_cmd.use_hold = 1'b1;
                    n_state        = i_status.wrap ? ST_IDLE : ST_RUN;
                end
            end
            ST_RUN: begin
                o_in_stall = !i_status.out_free;
                if (i_in_valid && i_status.out_free) begin
                    o_cmd.fire = 1'b1;
                    if (i_status.wrap) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        o_cmd.idx       = r_idx;
        o_cmd.last_axis = n_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
            r_last  <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_last  <= n_last;
        end
    end

endmodule

FILE: rtl/tpag_dp.sv
// Datapath of the tensor permute address generator: stride and step tables,
// axis counters, address register and the output register. Depends on tpag_pkg.
module tpag_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tpag_pkg::t_dp_cmd                 i_cmd,
    input  logic [tpag_pkg::ORDER_BITS-1:0]   i_axis_order,
    input  logic [tpag_pkg::CFG_W-1:0]        i_sizes_low,
    input  logic [tpag_pkg::CFG_W-1:0]        i_sizes_high,
    input  logic [tpag_pkg::ELEM_W-1:0]       i_element_data,
    input  logic                              i_out_stall,
    output tpag_pkg::t_dp_status              o_status,
    output logic                              o_out_valid,
    output logic [tpag_pkg::OUT_ADDR_W-1:0]   o_dest_address,
    output logic [tpag_pkg::ELEM_W-1:0]       o_element_out,
    output logic                              o_last_element
);
    import tpag_pkg::*;

    logic [2*CFG_W-1:0]   w_sizes;
    logic [SIZE_BITS-1:0] r_limit  [NUM_AXES];
    logic [SIZE_BITS-1:0] r_cnt    [NUM_AXES];
    logic [SIZE_BITS-1:0] n_cnt    [NUM_AXES];
    logic [ADDR_BITS-1:0] r_stride [NUM_AXES];
    logic [ADDR_BITS-1:0] r_step   [NUM_AXES];
    logic [NUM_AXES-1:0]  r_claim;
    logic [ADDR_BITS-1:0] r_acc, n_acc;
    logic [ADDR_BITS-1:0] r_prod, n_prod;
    logic [ADDR_BITS-1:0] r_suffix;
    logic [ADDR_BITS-1:0] r_addr, n_addr;
    logic [DATA_BITS-1:0] r_hold;
    logic [ADDR_BITS-1:0] r_out_addr;
    logic [DATA_BITS-1:0] r_out_data;
    logic                 r_out_last;
    logic                 r_out_valid;

    t_axis                w_src, w_lim_idx, w_k;
    logic [SIZE_BITS-1:0] w_lim;
    logic [ADDR_BITS-1:0] w_stride_rd;
    logic [NUM_AXES-1:0]  w_notfull;
    logic                 w_found;
    logic                 w_out_free;

    assign w_sizes     = {i_sizes_high, i_sizes_low};
    assign w_src       = i_axis_order[i_cmd.idx*ORDER_W +: ORDER_W];
    assign w_lim_idx   = i_cmd.stride_step ? w_src : i_cmd.idx;
    assign w_lim       = r_limit[w_lim_idx];
    assign w_stride_rd = r_stride[i_cmd.idx];
    assign n_acc       = ADDR_BITS'(r_acc * (ADDR_BITS'(w_lim) + ADDR_BITS'(1)));
    assign n_prod      = ADDR_BITS'(w_stride_rd * ADDR_BITS'(w_lim));
    assign w_out_free  = !r_out_valid || !i_out_stall;

    // Odometer: the highest axis in use that is below its limit advances.
    always_comb begin
        w_found = 1'b0;
        w_k     = '0;
        for (int a = 0; a < NUM_AXES; a++) begin
            w_notfull[a] = (AXIS_W'(a) <= i_cmd.last_axis) && (r_cnt[a] < r_limit[a]);
            if (w_notfull[a]) begin
                w_found = 1'b1;
                w_k     = AXIS_W'(a);
            end
        end
        for (int a = 0; a < NUM_AXES; a++) begin
            if (!w_found) begin
                n_cnt[a] = '0;
            end else if (AXIS_W'(a) == w_k) begin
                n_cnt[a] = SIZE_BITS'(r_cnt[a] + 1'b1);
            end else if (AXIS_W'(a) > w_k && AXIS_W'(a) <= i_cmd.last_axis) begin
                n_cnt[a] = '0;
            end else begin
                n_cnt[a] = r_cnt[a];
            end
        end
        n_addr = w_found ? ADDR_BITS'(r_addr + r_step[w_k]) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.fire) begin
            r_out_valid <= 1'b1;
        end else if (w_out_free) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                r_limit[a]  <= w_sizes[a*FIELD_W +: SIZE_BITS];
                r_cnt[a]    <= '0;
                r_stride[a] <= (AXIS_W'(a) == i_cmd.last_axis) ? ADDR_BITS'(1) : '0;
            end
            r_claim  <= '0;
            r_acc    <= ADDR_BITS'(1);
            r_suffix <= '0;
            r_addr   <= '0;
            r_hold   <= i_element_data[DATA_BITS-1:0];
        end
        // Walking down the destination axes, the first claim of a source axis
        // belongs to the highest destination axis, which is the one that counts.
        if (i_cmd.stride_step) begin
            if (!r_claim[w_src]) begin
                r_stride[w_src] <= r_acc;
                r_claim[w_src]  <= 1'b1;
            end
            r_acc <= n_acc;
        end
        if (i_cmd.rw_mul) begin
            r_prod <= n_prod;
        end
        if (i_cmd.rw_acc) begin
            r_step[i_cmd.idx] <= ADDR_BITS'(w_stride_rd - r_suffix);
            r_suffix          <= ADDR_BITS'(r_suffix + r_prod);
        end
        if (i_cmd.fire) begin
            r_out_addr <= r_addr;
            r_out_data <= i_cmd.use_hold ? r_hold : i_element_data[DATA_BITS-1:0];
            r_out_last <= !w_found;
            r_addr     <= n_addr;
            r_cnt      <= n_cnt;
        end
    end

    assign o_status.wrap     = !w_found;
    assign o_status.out_free = w_out_free;
    assign o_out_valid       = r_out_valid;
    assign o_dest_address    = OUT_ADDR_W'(r_out_addr);
    assign o_element_out     = ELEM_W'(r_out_data);
    assign o_last_element    = r_out_last;

endmodule

FILE: rtl/tpag_checker.sv
// Port-level checker for the tensor permute address generator, bound to the top level.
// Depends on tpag_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tpag_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_stall,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic [tpag_pkg::OUT_ADDR_W-1:0]   o_dest_address,
    input logic [tpag_pkg::ELEM_W-1:0]       o_element_out,
    input logic                              o_last_element
);
    import tpag_pkg::*;

    logic       w_in_xfer;
    logic       w_out_xfer;
    logic [1:0] r_pending;

    assign w_in_xfer  = i_in_valid && !o_in_stall;
    assign w_out_xfer = o_out_valid && !i_out_stall;

    // Elements taken in whose result has not yet been transferred out.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= 2'(r_pending + 2'(w_in_xfer) - 2'(w_out_xfer));
        end
    end

    `TPAG_ASSERT(a_no_spurious_result, i_clk, i_rst_n, w_out_xfer |-> (r_pending != 2'd0), "result transfer without an element in flight")
    `TPAG_ASSERT(a_pending_bound, i_clk, i_rst_n, (w_in_xfer && r_pending == 2'd2) |-> w_out_xfer, "more than two elements in flight")
    `TPAG_ASSERT(a_out_hold, i_clk, i_rst_n, (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_dest_address) && $stable(o_element_out) && $stable(o_last_element)), "stalled result changed")
    `TPAG_ASSERT_NR(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")

endmodule

bind tensor_permute_address_gen_unit tpag_checker u_tpag_checker (.*);

FILE: bench/tensor_permute_address_gen_unit_test.sv
// Self-checking testbench for tensor_permute_address_gen_unit.
// Depends on tpag_pkg and the unit itself. A scoreboard class predicts every
// destination address, and plain tasks drive the stream and configuration ports.
`timescale 1ns / 1ps

module tensor_permute_address_gen_unit_test;
    import tpag_pkg::*;

    // Receiver stall patterns. Each one runs for a random stretch of cycles.
    localparam int STALL_NONE   = 0;
    localparam int STALL_LIGHT  = 1;
    localparam int STALL_HEAVY  = 2;
    localparam int STALL_TOGGLE = 3;

    localparam int RANDOM_ITEMS = 500;
    localparam int DRAIN_CYCLES = 3 * MAX_RANK + 8;

    // One expected transfer on the output channel.
    typedef struct packed {
        logic [OUT_ADDR_W-1:0] addr;
        logic [ELEM_W-1:0]     word;
        logic                  last;
    } t_dest_item;

    // The scoreboard keeps its own copy of the configuration registers and of
    // the odometer. Every accepted element is stepped through that copy, and the
    // result it predicts waits in a queue until the block hands its result over.
    class t_dest_scoreboard;
        logic [RANK_W-1:0]     reg_rank;
        logic [ORDER_BITS-1:0] reg_order;
        logic [CFG_W-1:0]      reg_sizes_low;
        logic [CFG_W-1:0]      reg_sizes_high;

        logic [SIZE_BITS-1:0]  limit_of [NUM_AXES];
        logic [FIELD_W-1:0]    odometer [NUM_AXES];
        logic [ADDR_BITS-1:0]  stride_of [NUM_AXES];
        logic [ADDR_BITS-1:0]  rewind_of [NUM_AXES];
        logic [ADDR_BITS-1:0]  walk_addr;
        int                    live_rank;
        bit                    in_tensor;

        t_dest_item            awaited [$];
        int                    mismatch_count;

        function new();
            reg_rank       = RANK_RESET;
            reg_order      = ORDER_RESET;
            reg_sizes_low  = '0;
            reg_sizes_high = '0;
            walk_addr      = '0;
            live_rank      = 1;
            in_tensor      = 1'b0;
            mismatch_count = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_RANK:       reg_rank       = data[RANK_W-1:0];
                REG_AXIS_ORDER: reg_order      = data[ORDER_BITS-1:0];
                REG_SIZES_LOW:  reg_sizes_low  = data;
                REG_SIZES_HIGH: reg_sizes_high = data;
                default: ;
            endcase
        endfunction

        // Latch rank and sizes at a tensor start, and rebuild both tables.
        function void latch_tensor();
            logic [ADDR_BITS-1:0] span;
            logic [ADDR_BITS-1:0] dest_stride [NUM_AXES];
            logic [FIELD_W-1:0]   field;
            int                   src;
            if (reg_rank == '0) begin
                live_rank = 1;
            end else if (int'(reg_rank) > MAX_RANK) begin
                live_rank = MAX_RANK;
            end else begin
                live_rank = int'(reg_rank);
            end
            for (int a = 0; a < NUM_AXES; a++) begin
                field = (a < 4) ? reg_sizes_low[FIELD_W*a +: FIELD_W]
                                : reg_sizes_high[FIELD_W*(a-4) +: FIELD_W];
                limit_of[a]    = field[SIZE_BITS-1:0];
                stride_of[a]   = '0;
                odometer[a]    = '0;
                dest_stride[a] = '0;
            end
            // The last axis in use starts with a unit stride even when the
            // order never names it.
            stride_of[live_rank-1] = 1;
            span = 1;
            for (int b = live_rank - 1; b >= 0; b--) begin
                src            = int'(reg_order[ORDER_W*b +: ORDER_W]);
                dest_stride[b] = span;
                span           = span * (ADDR_BITS'(limit_of[src]) + 1'b1);
            end
            // Later destination axes win where the order repeats a source axis.
            for (int b = 0; b < live_rank; b++) begin
                src            = int'(reg_order[ORDER_W*b +: ORDER_W]);
                stride_of[src] = dest_stride[b];
            end
            for (int a = 0; a < NUM_AXES; a++) begin
                rewind_of[a] = stride_of[a] * ADDR_BITS'(limit_of[a]);
            end
            walk_addr = '0;
            in_tensor = 1'b1;
        endfunction

        function void note_element(logic [ELEM_W-1:0] word);
            t_dest_item item;
            int         ax;
            bit         carry;
            if (!in_tensor) begin
                latch_tensor();
            end
            item.addr = walk_addr[OUT_ADDR_W-1:0];
            item.word = word;
            carry = 1'b1;
            ax    = live_rank - 1;
            while (carry && ax >= 0) begin
                if (odometer[ax] < FIELD_W'(limit_of[ax])) begin
                    odometer[ax] = odometer[ax] + 1'b1;
                    walk_addr    = walk_addr + stride_of[ax];
                    carry        = 1'b0;
                end else begin
                    odometer[ax] = '0;
                    walk_addr    = walk_addr - rewind_of[ax];
                    ax           = ax - 1;
                end
            end
            // A carry out of axis 0 ends the tensor and sends the block idle.
            if (carry) begin
                walk_addr = '0;
                in_tensor = 1'b0;
            end
            item.last = carry;
            awaited.push_back(item);
        endfunction

        function void log_mismatch(string msg);
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("%t mismatch: %s", $realtime, msg);
            end
        endfunction

        function void check_result(logic [OUT_ADDR_W-1:0] addr, logic [ELEM_W-1:0] word,
                                   logic last);
            t_dest_item want;
            if (awaited.size() == 0) begin
                log_mismatch($sformatf("unexpected result addr %h word %h last %b",
                                       addr, word, last));
                return;
            end
            want = awaited.pop_front();
            if (addr !== want.addr) begin
                log_mismatch($sformatf("dest_address expected %h got %h", want.addr, addr));
            end
            if (word !== want.word) begin
                log_mismatch($sformatf("element_out expected %h got %h", want.word, word));
            end
            if (last !== want.last) begin
                log_mismatch($sformatf("last_element expected %b got %b (addr %h)",
                                       want.last, last, want.addr));
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    // Every input is known from time zero.
    logic                    i_clk          = 1'b0;
    logic                    i_rst_n        = 1'b0;
    logic                    i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_index    = REG_RANK;
    logic [CFG_W-1:0]        i_cfg_data     = '0;
    logic                    i_in_valid     = 1'b0;
    logic [ELEM_W-1:0]       i_element_data = '0;
    logic                    i_out_stall    = 1'b0;
    logic                    o_in_stall;
    logic                    o_out_valid;
    logic [OUT_ADDR_W-1:0]   o_dest_address;
    logic [ELEM_W-1:0]       o_element_out;
    logic                    o_last_element;

    t_dest_scoreboard sb;
    int               stall_mode = STALL_NONE;
    int               stall_span = 0;

    tensor_permute_address_gen_unit DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_element_data (i_element_data),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_dest_address (o_dest_address),
        .o_element_out  (o_element_out),
        .o_last_element (o_last_element)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Both channels are observed at the rising edge, before any of the
    // nonblocking updates of that edge land, so a transfer is seen exactly when
    // the block sees it. A result is registered after its element is taken, so
    // checking before noting the new element is safe.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                sb.check_result(o_dest_address, o_element_out, o_last_element);
            end
            if (i_in_valid && !o_in_stall) begin
                sb.note_element(i_element_data);
            end
        end
    end

    // The receiver switches between stall patterns of its own, including long
    // stretches with no stall at all.
    always @(posedge i_clk) begin
        if (stall_span == 0) begin
            stall_mode = $urandom_range(STALL_NONE, STALL_TOGGLE);
            stall_span = $urandom_range(16, 96);
        end
        stall_span = stall_span - 1;
        case (stall_mode)
            STALL_NONE:  i_out_stall <= 1'b0;
            STALL_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: i_out_stall <= ($urandom_range(0, 9) < 7);
            default:     i_out_stall <= ~i_out_stall;
        endcase
    end

    // One register write, taken at the next rising edge. The caller lowers the
    // write enable once the last register of a group is in.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    task automatic program_shape(input logic [RANK_W-1:0] rank_val,
                                 input logic [ORDER_BITS-1:0] order,
                                 input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi);
        write_reg(REG_RANK, CFG_W'(rank_val));
        write_reg(REG_AXIS_ORDER, CFG_W'(order));
        write_reg(REG_SIZES_LOW, lo);
        write_reg(REG_SIZES_HIGH, hi);
        i_cfg_we <= 1'b0;
    endtask

    // Offers one element and holds it until the transfer happens. Valid is
    // left high so that a following element goes out back to back.
    task automatic offer_element(input logic [ELEM_W-1:0] word);
        i_in_valid     <= 1'b1;
        i_element_data <= word;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
    endtask

    // Random elements in bursts of random length with random gaps between them.
    task automatic stream_elements(input int count);
        int left;
        int burst;
        int gap;
        left = count;
        while (left > 0) begin
            burst = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
            while (burst > 0 && left > 0) begin
                offer_element({$urandom, $urandom});
                burst--;
                left--;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b0;
    endtask

    // Waits until every predicted result has arrived. The queue is read at the
    // falling edge, after the monitor has dealt with the rising edge.
    task automatic settle();
        do begin
            @(negedge i_clk);
        end while (sb.pending() != 0);
        @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Number of elements in one tensor of the given shape.
    function automatic int tensor_length(input logic [RANK_W-1:0] rank_val,
                                         input logic [CFG_W-1:0] lo,
                                         input logic [CFG_W-1:0] hi);
        int r;
        int n;
        r = (rank_val == '0) ? 1 : ((int'(rank_val) > MAX_RANK) ? MAX_RANK : int'(rank_val));
        n = 1;
        for (int a = 0; a < r; a++) begin
            n = n * (1 + int'((a < 4) ? lo[FIELD_W*a +: SIZE_BITS]
                                      : hi[FIELD_W*(a-4) +: SIZE_BITS]));
        end
        return n;
    endfunction

    // A random tensor shape. The axes in use stay small so that tensors end
    // often; the axes above the rank carry random sizes, which still enter the
    // strides whenever a loose order names them.
    task automatic pick_shape(output logic [RANK_W-1:0] rank_val,
                              output logic [ORDER_BITS-1:0] order,
                              output logic [CFG_W-1:0] lo, output logic [CFG_W-1:0] hi);
        int r;
        int pick;
        int span;
        int cap;
        int j;
        int tmp;
        int perm [NUM_AXES];
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            rank_val = '0;
        end else if (pick == 1) begin
            rank_val = RANK_W'($urandom_range(MAX_RANK + 1, 15));
        end else begin
            rank_val = RANK_W'($urandom_range(1, MAX_RANK));
        end
        r = (rank_val == '0) ? 1 : ((int'(rank_val) > MAX_RANK) ? MAX_RANK : int'(rank_val));

        lo   = {$urandom, $urandom};
        hi   = {$urandom, $urandom};
        span = 1;
        for (int a = 0; a < r; a++) begin
            cap = 48 / span - 1;
            if (cap > 3) begin
                cap = 3;
            end
            tmp  = $urandom_range(0, cap);
            span = span * (tmp + 1);
            if (a < 4) begin
                lo[FIELD_W*a +: FIELD_W] = FIELD_W'(tmp);
            end else begin
                hi[FIELD_W*(a-4) +: FIELD_W] = FIELD_W'(tmp);
            end
        end

        // Mostly a true permutation, sometimes the identity (a plain copy), and
        // otherwise a loose order that may repeat axes or name unused ones.
        order = ORDER_BITS'($urandom);
        pick  = $urandom_range(0, 19);
        if (pick < 13) begin
            for (int a = 0; a < r; a++) begin
                perm[a] = a;
            end
            if (pick < 10) begin
                for (int a = r - 1; a > 0; a--) begin
                    j       = $urandom_range(0, a);
                    tmp     = perm[a];
                    perm[a] = perm[j];
                    perm[j] = tmp;
                end
            end
            for (int b = 0; b < r; b++) begin
                order[ORDER_W*b +: ORDER_W] = ORDER_W'(perm[b]);
            end
        end
    endtask

    initial begin
        logic [RANK_W-1:0]     rank_val;
        logic [ORDER_BITS-1:0] order;
        logic [CFG_W-1:0]      lo;
        logic [CFG_W-1:0]      hi;
        int                    sent;
        int                    count;

        sb = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // With the reset shape (one axis of size one) every element is a
        // tensor of its own, so each result ends a tensor at address zero.
        offer_element('0);
        offer_element('1);
        offer_element({ELEM_W/4{4'hA}});
        offer_element({ELEM_W/4{4'h5}});
        i_in_valid <= 1'b0;
        settle();

        // A rank of zero behaves as one; all unused size bits are set.
        program_shape('0, ORDER_RESET, 64'hFFFF_FFFF_FFFF_0002, '1);
        stream_elements(3);
        settle();

        // A rank above the maximum saturates; all eight axes with a reversed order.
        program_shape(4'hF, 24'h053977, 64'h0000_0000_0000_0001, 64'h0001_0000_0000_0000);
        stream_elements(4);
        settle();

        // The identity order gives sequential addresses.
        program_shape(4'd3, 24'h000088, 64'h0000_0001_0001_0001, '0);
        stream_elements(8);
        settle();

        // A loose order naming an unused axis twice, with a full-size field there.
        program_shape(4'd2, 24'h00002D, 64'h0000_0000_0002_0001, 64'h0000_0000_FFFF_0000);
        stream_elements(6);
        settle();

        // Random shapes, each run for a whole number of tensors so that every
        // register change falls at a tensor boundary.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            pick_shape(rank_val, order, lo, hi);
            program_shape(rank_val, order, lo, hi);
            count = tensor_length(rank_val, lo, hi) * $urandom_range(1, 3);
            stream_elements(count);
            sent += count;
            settle();
        end

        // Nothing may arrive once the last result is in.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        if (sb.mismatch_count == 0 && sb.pending() == 0) begin
            $display("** tensor_permute_address_gen_unit: PASSED **");
        end else begin
            $display("** tensor_permute_address_gen_unit: FAILED **");
        end
        $finish;
    end

    // Safety net: a correct run needs a small fraction of this.
    initial begin
        #4_000_000;
        $display("** tensor_permute_address_gen_unit: FAILED **");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/tpag_pkg.sv
rtl/tpag_ctrl.sv
rtl/tpag_dp.sv
rtl/tensor_permute_address_gen_unit.sv
rtl/tpag_checker.sv
bench/tensor_permute_address_gen_unit_test.sv
